>>> src/i2cm_pkg.sv
// i2cm_pkg: command codes, bus phase encoding and the word types shared by the
// i2c master bit engine modules. Depends on nothing.

package i2cm_pkg;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ADDR  = 3'd5;

  localparam logic [7:0] ADDR_RD_MASK  = 8'h01;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_SETUP = 4'b0010,
    PH_HIGH  = 4'b0100,
    PH_HOLD  = 4'b1000
  } phase_t;

  // one tick word as taken from the input channel
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       addr_read;
    logic       last_read;
    logic       sda_in;
  } tick_t;

  // engine state apart from the tick counter, whose width is a parameter
  typedef struct packed {
    phase_t     phase;
    logic [2:0] active_cmd;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic       ack_flag;
    logic       nack_pending;
    logic       scl;
    logic       sda;
    logic [7:0] rx_hold;
  } state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] rx_byte;
  } res_t;

endpackage

>>> src/i2cm_ifs.sv
// i2cm_ifs: valid/ready channel interfaces of the i2c master bit engine
// (tick input, result output, half-period configuration). No dependencies.

interface i2cm_tick_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       addr_read;
  logic       last_read;
  logic       sda_in;

  modport source (output valid, cmd, tx_byte, addr_read, last_read, sda_in, input ready);
  modport sink   (input valid, cmd, tx_byte, addr_read, last_read, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic       nack_seen;
  logic [7:0] rx_byte;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, nack_seen, rx_byte,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, nack_seen, rx_byte,
                  output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] half_period;

  modport source (output valid, half_period, input ready);
  modport sink   (input valid, half_period, output ready);
endinterface

>>> src/i2cm_step.sv
// i2cm_step: next-state and result logic for one tick of the bit engine.
// Purely combinational; depends on i2cm_pkg.

module i2cm_step #(
  parameter int DELAY_BITS = 16
) (
  input  i2cm_pkg::state_t        st_i,
  input  logic [DELAY_BITS-1:0]   tick_cnt_i,
  input  logic [DELAY_BITS-1:0]   half_period_i,
  input  i2cm_pkg::tick_t         tick_i,
  output i2cm_pkg::state_t        st_o,
  output logic [DELAY_BITS-1:0]   tick_cnt_o,
  output i2cm_pkg::res_t          res_o
);

  localparam logic [DELAY_BITS-1:0] CNT_ONE = DELAY_BITS'(1);

  logic       is_read;
  logic       phase_over;
  logic       done;
  logic [7:0] tx_sh;
  logic [7:0] new_sh;
  logic [3:0] new_bits;

  always_comb begin
    st_o       = st_i;
    tick_cnt_o = tick_cnt_i;
    done       = 1'b0;
    is_read    = (st_i.active_cmd == i2cm_pkg::CMD_READ);
    phase_over = (tick_cnt_i >= half_period_i);
    tx_sh      = tick_i.tx_byte |
                 (((tick_i.cmd == i2cm_pkg::CMD_ADDR) && tick_i.addr_read) ?
                  i2cm_pkg::ADDR_RD_MASK : 8'h00);
    new_sh     = is_read ? {st_i.shift_reg[6:0], tick_i.sda_in} :
                           {st_i.shift_reg[6:0], 1'b0};
    new_bits   = st_i.bit_count + 4'd1;

    case (st_i.phase)
      i2cm_pkg::PH_IDLE: begin
        if (tick_i.cmd >= i2cm_pkg::CMD_START && tick_i.cmd <= i2cm_pkg::CMD_ADDR) begin
          st_o.active_cmd = tick_i.cmd;
          st_o.phase      = i2cm_pkg::PH_SETUP;
          st_o.scl        = 1'b0;
          st_o.bit_count  = 4'd0;
          case (tick_i.cmd)
            i2cm_pkg::CMD_START: st_o.sda = 1'b1;
            i2cm_pkg::CMD_STOP:  st_o.sda = 1'b0;
            i2cm_pkg::CMD_READ: begin
              st_o.shift_reg    = 8'h00;
              st_o.nack_pending = tick_i.last_read;
              st_o.sda          = 1'b1;
            end
            default: begin
              st_o.shift_reg = tx_sh;
              st_o.sda       = tx_sh[7];
            end
          endcase
        end
      end
      i2cm_pkg::PH_SETUP: begin
        st_o.scl   = 1'b1;
        tick_cnt_o = CNT_ONE;
        st_o.phase = i2cm_pkg::PH_HIGH;
      end
      i2cm_pkg::PH_HIGH: begin
        if (!phase_over) begin
          tick_cnt_o = tick_cnt_i + CNT_ONE;
        end else if (st_i.active_cmd == i2cm_pkg::CMD_START) begin
          st_o.sda   = 1'b0;
          tick_cnt_o = CNT_ONE;
          st_o.phase = i2cm_pkg::PH_HOLD;
        end else if (st_i.active_cmd == i2cm_pkg::CMD_STOP) begin
          st_o.sda   = 1'b1;
          tick_cnt_o = CNT_ONE;
          st_o.phase = i2cm_pkg::PH_HOLD;
        end else begin
          st_o.scl = 1'b0;
          if (st_i.bit_count < i2cm_pkg::BITS_PER_BYTE) begin
            st_o.shift_reg = new_sh;
            st_o.bit_count = new_bits;
            // ninth clock: ack level for reads, released for writes
            if (new_bits == i2cm_pkg::BITS_PER_BYTE) begin
              st_o.sda = is_read ? st_i.nack_pending : 1'b1;
            end else begin
              st_o.sda = is_read ? 1'b1 : new_sh[7];
            end
            st_o.phase = i2cm_pkg::PH_SETUP;
          end else begin
            if (is_read) begin
              st_o.rx_hold = st_i.shift_reg;
            end else begin
              st_o.ack_flag = tick_i.sda_in;
            end
            st_o.phase      = i2cm_pkg::PH_IDLE;
            st_o.active_cmd = i2cm_pkg::CMD_NONE;
            done            = 1'b1;
          end
        end
      end
      i2cm_pkg::PH_HOLD: begin
        if (!phase_over) begin
          tick_cnt_o = tick_cnt_i + CNT_ONE;
        end else begin
          if (st_i.active_cmd == i2cm_pkg::CMD_START) begin
            st_o.scl = 1'b0;
          end
          st_o.phase      = i2cm_pkg::PH_IDLE;
          st_o.active_cmd = i2cm_pkg::CMD_NONE;
          done            = 1'b1;
        end
      end
      default: begin
        st_o.phase      = i2cm_pkg::PH_IDLE;
        st_o.active_cmd = i2cm_pkg::CMD_NONE;
      end
    endcase

    res_o.scl_out   = st_o.scl;
    res_o.sda_out   = st_o.sda;
    res_o.busy_res  = (st_o.phase != i2cm_pkg::PH_IDLE);
    res_o.done_res  = done;
    res_o.nack_seen = st_o.ack_flag;
    res_o.rx_byte   = st_o.rx_hold;
  end

endmodule

>>> src/i2c_master_bit_engine.sv
// i2c_master_bit_engine: top level with tick input register, engine state,
// result register and half-period register. Depends on i2cm_pkg, i2cm_ifs, i2cm_step.

// Each accepted tick word gives exactly one result word: it lands in the
// input register, the step logic updates the engine state from it and loads
// the result register. The engine state is a single set of registers fed
// back to the step logic, so throughput is one tick per cycle unless the
// output stalls, and is set by that loop. in_ch.ready drops only while both
// registers are full and out_ch.ready is low. The half-period register takes
// a write whenever cfg_ch.valid is high and should be written only while the
// engine is idle; its value is held modulo 2**DELAY_BITS.

module i2c_master_bit_engine #(
  parameter int DELAY_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  i2cm_tick_if.sink      in_ch,
  i2cm_res_if.source     out_ch,
  i2cm_cfg_if.sink       cfg_ch
);

  localparam logic [DELAY_BITS-1:0] HP_RESET = DELAY_BITS'(32'd100);

  logic                   in_valid_r;
  i2cm_pkg::tick_t        in_word_r;
  logic                   out_valid_r;
  i2cm_pkg::res_t         out_word_r;
  i2cm_pkg::state_t       st_r;
  i2cm_pkg::state_t       st_nxt;
  logic [DELAY_BITS-1:0]  tick_cnt_r;
  logic [DELAY_BITS-1:0]  tick_cnt_nxt;
  logic [DELAY_BITS-1:0]  half_period_r;
  i2cm_pkg::res_t         res_nxt;
  logic                   advance;
  logic                   in_fire;

  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  i2cm_step #(
    .DELAY_BITS(DELAY_BITS)
  ) u_step (
    .st_i          (st_r),
    .tick_cnt_i    (tick_cnt_r),
    .half_period_i (half_period_r),
    .tick_i        (in_word_r),
    .st_o          (st_nxt),
    .tick_cnt_o    (tick_cnt_nxt),
    .res_o         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tick_cnt_r  <= '0;
      half_period_r <= HP_RESET;
      st_r.phase        <= i2cm_pkg::PH_IDLE;
      st_r.active_cmd   <= i2cm_pkg::CMD_NONE;
      st_r.bit_count    <= 4'd0;
      st_r.shift_reg    <= 8'h00;
      st_r.ack_flag     <= 1'b0;
      st_r.nack_pending <= 1'b0;
      st_r.scl          <= 1'b1;
      st_r.sda          <= 1'b1;
      st_r.rx_hold      <= 8'h00;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
        tick_cnt_r  <= tick_cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        half_period_r <= DELAY_BITS'(cfg_ch.half_period);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_word_r.cmd       <= in_ch.cmd;
      in_word_r.tx_byte   <= in_ch.tx_byte;
      in_word_r.addr_read <= in_ch.addr_read;
      in_word_r.last_read <= in_ch.last_read;
      in_word_r.sda_in    <= in_ch.sda_in;
    end
    if (advance) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_out   = out_word_r.scl_out;
  assign out_ch.sda_out   = out_word_r.sda_out;
  assign out_ch.busy_res  = out_word_r.busy_res;
  assign out_ch.done_res  = out_word_r.done_res;
  assign out_ch.nack_seen = out_word_r.nack_seen;
  assign out_ch.rx_byte   = out_word_r.rx_byte;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done reported while still busy");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed tick gave no result word");

  a_setup_to_high: assert property (@(posedge clk) disable iff (!rst_n)
    advance && st_r.phase == i2cm_pkg::PH_SETUP |=>
      st_r.phase == i2cm_pkg::PH_HIGH && st_r.scl)
    else $error("setup tick did not raise scl");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r) && $stable(tick_cnt_r))
    else $error("engine state moved without a tick");

endmodule
